/* rtl/lphi_pkg.sv */
// shared constants and types for the linear probing hash insert block
package lphi_pkg;

  localparam int TABLE_SIZE = 1024;
  localparam int TAG_WIDTH  = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int PROBE_W    = 11;
  localparam int COUNT_W    = 32;
  localparam int IN_IDX_W   = 10;
  localparam int SLOT_OUT_W = 10;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 88;
  localparam int ENTRY_W    = TAG_WIDTH + 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                  valid;
    logic [IDX_W-1:0]      placed_slot;
    logic [PROBE_W-1:0]    probe_count;
    logic                  table_full;
    logic                  chain_hit;
  } lphi_result_t;

endpackage

/* rtl/linear_probe_hash_insert.sv */
// top level of the linear probing hash insert block
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one insert item: a home slot index and a
//   tag. m_tvalid/m_tready/m_tdata return one result item per insert: slot
//   used, probes spent, full flag, chained-bucket hit and both running totals.
//   an insert runs from acceptance to result in order: the home slot is read
//   at the accepting edge, then each slot examined is read in turn from
//   the slot memory (single read port, one probe per cycle), then the output
//   register is loaded. a full table walks all 1024 slots.
//   inserts are handled one at a time; the next one is accepted as soon as
//   the result has moved into the output register, even while it waits.
//   after reset the block sweeps both memories to zero, one entry a cycle,
//   through all 1024 entries, with s_tready low. totals restart at zero.
//   when the receiver stalls the result holds in the output register; a
//   following insert finishes its probe and waits in the engine.
module linear_probe_hash_insert (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // hash_index [9:0], entry_tag [25:10], zero fill [31:26]
  input  logic [lphi_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // placed_slot [9:0], probe_count [20:10], table_full [21], chain_hit [22],
  // open_total [54:23], chain_total [86:55], zero fill [87]
  output logic [lphi_pkg::OUT_W-1:0] m_tdata
);
  import lphi_pkg::*;

  lphi_result_t            res;
  logic                    take;

  logic [SLOT_OUT_W-1:0]   out_slot;
  logic [PROBE_W-1:0]      out_probes;
  logic                    out_full;
  logic                    out_hit;
  logic [COUNT_W-1:0]      open_total;
  logic [COUNT_W-1:0]      chain_total;
  logic [COUNT_W-1:0]      open_total_next;
  logic [COUNT_W-1:0]      chain_total_next;
  logic [COUNT_W:0]        open_sum;
  logic [COUNT_W:0]        chain_sum;

  lphi_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_index (s_tdata[IN_IDX_W-1:0]),
    .in_tag   (s_tdata[IN_IDX_W +: TAG_WIDTH]),
    .res      (res),
    .res_take (take)
  );

  // output register free or being emptied this cycle
  assign take = res.valid && (!m_tvalid || m_tready);

  // saturating totals
  assign open_sum  = {1'b0, open_total} + (COUNT_W+1)'(res.probe_count);
  assign chain_sum = {1'b0, chain_total} + (COUNT_W+1)'(res.chain_hit);
  assign open_total_next  = open_sum[COUNT_W]  ? COUNT_MAX : open_sum[COUNT_W-1:0];
  assign chain_total_next = chain_sum[COUNT_W] ? COUNT_MAX : chain_sum[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      open_total  <= '0;
      chain_total <= '0;
    end else begin
      if (take) begin
        m_tvalid    <= 1'b1;
        open_total  <= open_total_next;
        chain_total <= chain_total_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_slot   <= SLOT_OUT_W'(res.placed_slot);
      out_probes <= res.probe_count;
      out_full   <= res.table_full;
      out_hit    <= res.chain_hit;
    end
  end

  assign m_tdata = {1'b0, chain_total, open_total, out_hit, out_full,
                    out_probes, out_slot};

  a_load_on_take: assert property (@(posedge clk) disable iff (rst)
    take |=> m_tvalid)
    else $error("result not loaded into output register");

  a_open_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> open_total >= $past(open_total))
    else $error("open total went down");

  a_chain_step: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(chain_total))
    else $error("chain total changed without a result");

endmodule

/* rtl/lphi_ram.sv */
// generic single write port ram with registered read
module lphi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/lphi_engine.sv */
// probe engine: slot and bucket memories, clearing pass and probe sequencer
module lphi_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lphi_pkg::IN_IDX_W-1:0]  in_index,
  input  logic [lphi_pkg::TAG_WIDTH-1:0] in_tag,
  output lphi_pkg::lphi_result_t      res,
  input  logic                        res_take
);
  import lphi_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0]   LAST_SLOT  = IDX_W'(TABLE_SIZE - 1);
  localparam logic [PROBE_W-1:0] PROBE_FULL = PROBE_W'(TABLE_SIZE);

  state_t               state;
  logic [IDX_W-1:0]     clr_addr;
  logic [IDX_W-1:0]     home;
  logic [TAG_WIDTH-1:0] tag;
  logic [IDX_W-1:0]     pos;
  logic [PROBE_W-1:0]   probes;
  logic                 first;
  logic                 hit;
  logic                 full;

  logic                 accept;
  logic [IDX_W-1:0]     pos_inc;
  logic [PROBE_W-1:0]   probes_inc;
  logic [IDX_W-1:0]     in_home;

  logic                 slot_we;
  logic [IDX_W-1:0]     slot_waddr;
  logic [ENTRY_W-1:0]   slot_wdata;
  logic [IDX_W-1:0]     slot_raddr;
  logic [ENTRY_W-1:0]   slot_rdata;
  logic                 rd_used;
  logic                 rd_coll;
  logic [TAG_WIDTH-1:0] rd_tag;

  logic                 bkt_we;
  logic [IDX_W-1:0]     bkt_waddr;
  logic                 bkt_wdata;
  logic [IDX_W-1:0]     bkt_raddr;
  logic                 bkt_rdata;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign in_home    = in_index[IDX_W-1:0];
  assign pos_inc    = (pos == LAST_SLOT) ? '0 : pos + 1'b1;
  assign probes_inc = probes + 1'b1;

  assign rd_used = slot_rdata[ENTRY_W-1];
  assign rd_coll = slot_rdata[ENTRY_W-2];
  assign rd_tag  = slot_rdata[TAG_WIDTH-1:0];

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = pos;
    slot_wdata = rd_used ? {1'b1, 1'b1, rd_tag} : {1'b1, rd_coll, tag};
    slot_raddr = pos_inc;
    bkt_we     = 1'b0;
    bkt_waddr  = home;
    bkt_wdata  = 1'b1;
    bkt_raddr  = home;
    unique case (state)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_addr;
        slot_wdata = '0;
        bkt_we     = 1'b1;
        bkt_waddr  = clr_addr;
        bkt_wdata  = 1'b0;
      end
      ST_IDLE: begin
        slot_raddr = in_home;
        bkt_raddr  = in_home;
      end
      ST_PROBE: begin
        slot_we = 1'b1;
        bkt_we  = first && !bkt_rdata;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  lphi_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_slot_ram (
    .clk     (clk),
    .we      (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_addr (slot_raddr),
    .rd_data (slot_rdata)
  );

  lphi_ram #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_bucket_ram (
    .clk     (clk),
    .we      (bkt_we),
    .wr_addr (bkt_waddr),
    .wr_data (bkt_wdata),
    .rd_addr (bkt_raddr),
    .rd_data (bkt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_SLOT) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (!rd_used || probes_inc == PROBE_FULL) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      home   <= in_home;
      tag    <= in_tag;
      pos    <= in_home;
      probes <= '0;
      first  <= 1'b1;
      full   <= 1'b0;
    end else if (state == ST_PROBE) begin
      first <= 1'b0;
      if (first) begin
        hit <= bkt_rdata;
      end
      if (rd_used) begin
        probes <= probes_inc;
        if (probes_inc == PROBE_FULL) begin
          full <= 1'b1;
          pos  <= home;
        end else begin
          pos <= pos_inc;
        end
      end
    end
  end

  assign res.valid       = (state == ST_DONE);
  assign res.placed_slot = pos;
  assign res.probe_count = probes;
  assign res.table_full  = full;
  assign res.chain_hit   = hit;

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_PROBE |-> probes < PROBE_FULL)
    else $error("probe count ran past table size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE) |-> !slot_we && !bkt_we)
    else $error("memory written outside clear or probe");

  a_full_home: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.table_full |-> res.placed_slot == home)
    else $error("full table result does not give home slot");

endmodule
